// ===== rtl/bws_pkg.sv =====
// Shared types and constants for the bilinear warp sampler.
// Depends on nothing; every other rtl file imports it.
`default_nettype none

package bws_pkg;

  // Fixed field widths of the stream payload
  localparam int COORD_W     = 18;
  localparam int IDX_W       = 18;
  localparam int PIX_W       = 8;
  localparam int REG_W       = 10;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;

  // Weights are 4-bit fractions of sixteen; top-left may reach sixteen itself
  localparam int WGT_W    = 5;
  localparam int WGT_FRAC = 4;
  localparam int ACC_W    = 12;

  // Result queue
  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = 3;

  localparam logic [REG_W-1:0] IMG_DIM_RST = 10'd512;
  localparam logic [WGT_W-1:0] WGT_ONE     = 5'd16;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WGT_W-1:0] wgt_t;
  typedef logic [REG_W-1:0] dim_t;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  // Per-stage control: a pending store write, a pending sample and its off flag
  typedef struct packed {
    logic wr_en;
    logic smp;
    logic off;
  } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/bws_coord_unit.sv =====
// Coordinate front end: bounds check, row multiply, weights, neighbor addresses.
// Depends on bws_pkg. Three register stages; outputs feed the frame store and blend unit.
`default_nettype none

module bws_coord_unit #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 8,
  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  beat_vld,
  input  bws_pkg::cmd_t                        beat_cmd,
  input  wire  [bws_pkg::IDX_W-1:0]            beat_idx,
  input  wire  [bws_pkg::PIX_W-1:0]            beat_val,
  input  wire  signed [bws_pkg::COORD_W-1:0]   beat_x,
  input  wire  signed [bws_pkg::COORD_W-1:0]   beat_y,
  input  bws_pkg::dim_t                        img_w,
  input  bws_pkg::dim_t                        img_h,
  output bws_pkg::ctl_t                        ctl,
  output logic [ADDR_W-1:0]                    wr_addr,
  output bws_pkg::pix_t                        wr_data,
  output logic [ADDR_W-1:0]                    addr_tl,
  output logic [ADDR_W-1:0]                    addr_tr,
  output logic [ADDR_W-1:0]                    addr_bl,
  output logic [ADDR_W-1:0]                    addr_br,
  output bws_pkg::wgt_t                        w_tl,
  output bws_pkg::wgt_t                        w_tr,
  output bws_pkg::wgt_t                        w_bl,
  output bws_pkg::wgt_t                        w_br
);
  import bws_pkg::*;

  localparam int     MAG_W      = COORD_W - 1;
  localparam int     LIM_W      = REG_W + FRAC_BITS;
  localparam int     CMP_W      = (LIM_W > MAG_W) ? LIM_W : MAG_W;
  localparam int     PRD_W      = 2 * FRAC_BITS;
  localparam int     SHR        = PRD_W - WGT_FRAC;
  localparam int     SUM_W      = 2 * REG_W;
  localparam int     WR_W       = ((SUM_W > ADDR_W) ? SUM_W : ADDR_W) + 1;
  localparam longint STORE_SIZE = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
  localparam bit     STORE_POW2 = (STORE_SIZE == (longint'(1) << ADDR_W));

  // Wrap a neighbor address into the store
  function automatic logic [ADDR_W-1:0] wrap_addr(input logic [WR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    if (STORE_POW2) begin
      r = v[ADDR_W-1:0];
    end else if (v >= WR_W'(STORE_SIZE)) begin
      r = ADDR_W'(v - WR_W'(STORE_SIZE));
    end else begin
      r = ADDR_W'(v);
    end
    return r;
  endfunction

  // Stage 1: captured beat
  logic                       s1_vld_r;
  cmd_t                       s1_cmd_r;
  logic [IDX_W-1:0]           s1_idx_r;
  pix_t                       s1_val_r;
  logic signed [COORD_W-1:0]  s1_x_r;
  logic signed [COORD_W-1:0]  s1_y_r;

  // Stage 2: products
  ctl_t                       s2_ctl_r;
  logic [SUM_W-1:0]           s2_row_r;
  dim_t                       s2_ix_r;
  logic [FRAC_BITS-1:0]       s2_fx_r;
  logic [FRAC_BITS-1:0]       s2_fy_r;
  logic [PRD_W-1:0]           s2_pf_r;
  logic [ADDR_W-1:0]          s2_widx_r;
  pix_t                       s2_val_r;

  // Stage 3: base addresses and weights
  ctl_t                       s3_ctl_r;
  logic [SUM_W-1:0]           s3_base_r;
  logic [SUM_W-1:0]           s3_below_r;
  wgt_t                       s3_wtl_r;
  wgt_t                       s3_wtr_r;
  wgt_t                       s3_wbl_r;
  wgt_t                       s3_wbr_r;
  logic [ADDR_W-1:0]          s3_widx_r;
  pix_t                       s3_val_r;

  logic [MAG_W-1:0]     xm, ym;
  logic [CMP_W-1:0]     lim_x, lim_y;
  logic                 tiny, off;
  dim_t                 ix, iy;
  logic                 wr_ok;
  ctl_t                 s2_ctl_nxt;
  logic [SUM_W-1:0]     base;
  logic [PRD_W-1:0]     p_tr, p_bl;
  wgt_t                 wbr, wtr, wbl;

  always_comb begin
    xm    = s1_x_r[MAG_W-1:0];
    ym    = s1_y_r[MAG_W-1:0];
    tiny  = (img_w < REG_W'(2)) || (img_h < REG_W'(2));
    lim_x = CMP_W'(img_w - REG_W'(1)) << FRAC_BITS;
    lim_y = CMP_W'(img_h - REG_W'(1)) << FRAC_BITS;
    off   = s1_x_r[COORD_W-1] || s1_y_r[COORD_W-1] || tiny ||
            (CMP_W'(xm) >= lim_x) || (CMP_W'(ym) >= lim_y);
    ix    = REG_W'(xm >> FRAC_BITS);
    iy    = REG_W'(ym >> FRAC_BITS);
    wr_ok = longint'(s1_idx_r) < STORE_SIZE;

    s2_ctl_nxt.wr_en = s1_vld_r && (s1_cmd_r == CMD_WRITE) && wr_ok;
    s2_ctl_nxt.smp   = s1_vld_r && (s1_cmd_r == CMD_SAMPLE);
    s2_ctl_nxt.off   = off;
  end

  always_comb begin
    base = s2_row_r + SUM_W'(s2_ix_r);
    // fx*(1-fy) and (1-fx)*fy, reusing fx*fy
    p_tr = {s2_fx_r, FRAC_BITS'(0)} - s2_pf_r;
    p_bl = {s2_fy_r, FRAC_BITS'(0)} - s2_pf_r;
    wbr  = WGT_W'(s2_pf_r >> SHR);
    wtr  = WGT_W'(p_tr >> SHR);
    wbl  = WGT_W'(p_bl >> SHR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else begin
      s1_vld_r <= beat_vld;
      s2_ctl_r <= s2_ctl_nxt;
      s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r   <= beat_cmd;
    s1_idx_r   <= beat_idx;
    s1_val_r   <= beat_val;
    s1_x_r     <= beat_x;
    s1_y_r     <= beat_y;

    s2_row_r   <= SUM_W'(iy) * SUM_W'(img_w);
    s2_ix_r    <= ix;
    s2_fx_r    <= xm[FRAC_BITS-1:0];
    s2_fy_r    <= ym[FRAC_BITS-1:0];
    s2_pf_r    <= PRD_W'(xm[FRAC_BITS-1:0]) * PRD_W'(ym[FRAC_BITS-1:0]);
    s2_widx_r  <= ADDR_W'(s1_idx_r);
    s2_val_r   <= s1_val_r;

    s3_base_r  <= base;
    s3_below_r <= base + SUM_W'(img_w);
    s3_wbr_r   <= wbr;
    s3_wtr_r   <= wtr;
    s3_wbl_r   <= wbl;
    s3_wtl_r   <= WGT_ONE - wbr - wtr - wbl;
    s3_widx_r  <= s2_widx_r;
    s3_val_r   <= s2_val_r;
  end

  assign ctl     = s3_ctl_r;
  assign wr_addr = s3_widx_r;
  assign wr_data = s3_val_r;
  assign addr_tl = wrap_addr(WR_W'(s3_base_r));
  assign addr_tr = wrap_addr(WR_W'(s3_base_r) + WR_W'(1));
  assign addr_bl = wrap_addr(WR_W'(s3_below_r));
  assign addr_br = wrap_addr(WR_W'(s3_below_r) + WR_W'(1));
  assign w_tl    = s3_wtl_r;
  assign w_tr    = s3_wtr_r;
  assign w_bl    = s3_wbl_r;
  assign w_br    = s3_wbr_r;

endmodule

`default_nettype wire

// ===== rtl/bws_frame_store.sv =====
// Source frame store: two identical copies, each one write and two reads a cycle.
// Depends on bws_pkg. Read data is registered.
`default_nettype none

module bws_frame_store #(
  parameter int DEPTH = 262144,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire                 clk,
  input  wire                 wr_en,
  input  wire  [ADDR_W-1:0]   wr_addr,
  input  bws_pkg::pix_t       wr_data,
  input  wire                 rd_en,
  input  wire  [ADDR_W-1:0]   addr_tl,
  input  wire  [ADDR_W-1:0]   addr_tr,
  input  wire  [ADDR_W-1:0]   addr_bl,
  input  wire  [ADDR_W-1:0]   addr_br,
  output bws_pkg::pix_t       pix_tl,
  output bws_pkg::pix_t       pix_tr,
  output bws_pkg::pix_t       pix_bl,
  output bws_pkg::pix_t       pix_br
);
  import bws_pkg::*;

  // Upper copy serves the top row of the 2x2 window, lower copy the bottom row
  pix_t copy_up [DEPTH];
  pix_t copy_dn [DEPTH];

  pix_t rd_tl_r, rd_tr_r, rd_bl_r, rd_br_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      copy_up[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_tl_r <= copy_up[addr_tl];
      rd_tr_r <= copy_up[addr_tr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      copy_dn[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_bl_r <= copy_dn[addr_bl];
      rd_br_r <= copy_dn[addr_br];
    end
  end

  assign pix_tl = rd_tl_r;
  assign pix_tr = rd_tr_r;
  assign pix_bl = rd_bl_r;
  assign pix_br = rd_br_r;

endmodule

`default_nettype wire

// ===== rtl/bws_blend_unit.sv =====
// Blend stage: weighted sum of the 2x2 window (zero for an off-image sample), aligned with the store read data.
// Depends on bws_pkg.
`default_nettype none

module bws_blend_unit (
  input  wire             clk,
  input  wire             rst_n,
  input  bws_pkg::ctl_t   ctl,
  input  bws_pkg::wgt_t   w_tl,
  input  bws_pkg::wgt_t   w_tr,
  input  bws_pkg::wgt_t   w_bl,
  input  bws_pkg::wgt_t   w_br,
  input  bws_pkg::pix_t   pix_tl,
  input  bws_pkg::pix_t   pix_tr,
  input  bws_pkg::pix_t   pix_bl,
  input  bws_pkg::pix_t   pix_br,
  output logic            push,
  output bws_pkg::pix_t   push_pix,
  output logic            push_off
);
  import bws_pkg::*;

  logic  s4_smp_r;
  logic  s4_off_r;
  wgt_t  s4_wtl_r, s4_wtr_r, s4_wbl_r, s4_wbr_r;
  logic [ACC_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_smp_r <= 1'b0;
    end else begin
      s4_smp_r <= ctl.smp;
    end
  end

  always_ff @(posedge clk) begin
    s4_off_r <= ctl.off;
    s4_wtl_r <= w_tl;
    s4_wtr_r <= w_tr;
    s4_wbl_r <= w_bl;
    s4_wbr_r <= w_br;
  end

  always_comb begin
    acc = ACC_W'(pix_tl) * ACC_W'(s4_wtl_r) + ACC_W'(pix_tr) * ACC_W'(s4_wtr_r) +
          ACC_W'(pix_bl) * ACC_W'(s4_wbl_r) + ACC_W'(pix_br) * ACC_W'(s4_wbr_r);
    if (s4_off_r) begin
      push_pix = '0;
    end else if (s4_wtl_r == WGT_ONE) begin
      // Whole weight on top-left: copy it, the other neighbors are not needed
      push_pix = pix_tl;
    end else begin
      push_pix = acc[ACC_W-1:WGT_FRAC];
    end
  end

  assign push     = s4_smp_r;
  assign push_off = s4_off_r;

endmodule

`default_nettype wire

// ===== rtl/bws_out_queue.sv =====
// Result queue with slot reservation: a slot is booked when a sample beat is
// accepted, so the pipeline never stalls. Depends on bws_pkg.
`default_nettype none

module bws_out_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             reserve,
  output logic            can_reserve,
  input  wire             push,
  input  bws_pkg::pix_t   push_pix,
  input  wire             push_off,
  output logic            pop_vld,
  input  wire             pop_rdy,
  output bws_pkg::pix_t   pop_pix,
  output logic            pop_off
);
  import bws_pkg::*;

  pix_t               q_pix [Q_DEPTH];
  logic               q_off [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r, cnt_nxt;
  logic [Q_PTR_W:0]   resv_r, resv_nxt;
  logic               pop;

  assign pop         = pop_vld && pop_rdy;
  assign pop_vld     = (cnt_r != '0);
  assign pop_pix     = q_pix[rd_ptr_r];
  assign pop_off     = q_off[rd_ptr_r];
  assign can_reserve = (resv_r < (Q_PTR_W+1)'(Q_DEPTH));

  always_comb begin
    cnt_nxt  = cnt_r + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    resv_nxt = resv_r + (Q_PTR_W+1)'(reserve) - (Q_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      resv_r   <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      resv_r <= resv_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_pix[wr_ptr_r] <= push_pix;
      q_off[wr_ptr_r] <= push_off;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bilinear_warp_sampler_top.sv =====
// Bilinear warp sampler: 8-bit source frame store with 2x2 blend, weights in sixteenths.
// Throughput: one beat per cycle while the result queue has a free slot, writes and samples freely mixed.
// A sample beat accepted goes through three coordinate stages, one store read and
//   one blend into the result queue, then shows on out_*.
// Reset (rst_n low, synchronous): pipeline and queue empty, width and height
//   back to 512. Frame contents are left as they are; no clearing pass.
`default_nettype none

module bilinear_warp_sampler_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 8
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // Input stream
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [17:0] pixel_index, [25:18] pixel_value, [43:26] sample_x, [61:44] sample_y,
  // [63:62] zero
  input  wire  [bws_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] cmd (0 write pixel, 1 sample)
  input  wire  [0:0]                          in_tuser,
  // Result stream
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [7:0] blended_pixel
  output logic [bws_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [0] off_image
  output logic [0:0]                          out_tuser,
  // Configuration write port
  input  wire                                 cfg_we,
  input  bws_pkg::cfg_idx_t                   cfg_addr,
  input  wire  [bws_pkg::REG_W-1:0]           cfg_wdata
);
  import bws_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  // Field offsets in in_tdata
  localparam int OFS_IDX = 0;
  localparam int OFS_VAL = OFS_IDX + IDX_W;
  localparam int OFS_X   = OFS_VAL + PIX_W;
  localparam int OFS_Y   = OFS_X + COORD_W;

  // Configuration registers
  dim_t img_w_r, img_w_nxt;
  dim_t img_h_r, img_h_nxt;

  always_comb begin
    img_w_nxt = img_w_r;
    img_h_nxt = img_h_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_WIDTH:  img_w_nxt = cfg_wdata;
        CFG_HEIGHT: img_h_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_DIM_RST;
      img_h_r <= IMG_DIM_RST;
    end else begin
      img_w_r <= img_w_nxt;
      img_h_r <= img_h_nxt;
    end
  end

  // Accept whenever the result queue has a free slot for a possible sample.
  // Writes book no slot; they retire into the store in pipeline order, so a
  // sample behind a write always reads the new pixel.
  logic  accept;
  cmd_t  beat_cmd;
  logic  can_reserve;

  assign beat_cmd  = cmd_t'(in_tuser[0]);
  assign in_tready = can_reserve;
  assign accept    = in_tvalid && in_tready;

  ctl_t               s3_ctl;
  logic [ADDR_W-1:0]  wr_addr;
  pix_t               wr_data;
  logic [ADDR_W-1:0]  a_tl, a_tr, a_bl, a_br;
  wgt_t               w_tl, w_tr, w_bl, w_br;
  pix_t               p_tl, p_tr, p_bl, p_br;
  logic               push, push_off;
  pix_t               push_pix;
  pix_t               pop_pix;
  logic               pop_off;

  bws_coord_unit #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_coord (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat_vld (accept),
    .beat_cmd (beat_cmd),
    .beat_idx (in_tdata[OFS_IDX +: IDX_W]),
    .beat_val (in_tdata[OFS_VAL +: PIX_W]),
    .beat_x   (in_tdata[OFS_X +: COORD_W]),
    .beat_y   (in_tdata[OFS_Y +: COORD_W]),
    .img_w    (img_w_r),
    .img_h    (img_h_r),
    .ctl      (s3_ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .addr_tl  (a_tl),
    .addr_tr  (a_tr),
    .addr_bl  (a_bl),
    .addr_br  (a_br),
    .w_tl     (w_tl),
    .w_tr     (w_tr),
    .w_bl     (w_bl),
    .w_br     (w_br)
  );

  // Store access: one item per cycle, so a write and a read never meet
  bws_frame_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (s3_ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (s3_ctl.smp),
    .addr_tl (a_tl),
    .addr_tr (a_tr),
    .addr_bl (a_bl),
    .addr_br (a_br),
    .pix_tl  (p_tl),
    .pix_tr  (p_tr),
    .pix_bl  (p_bl),
    .pix_br  (p_br)
  );

  bws_blend_unit u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (s3_ctl),
    .w_tl     (w_tl),
    .w_tr     (w_tr),
    .w_bl     (w_bl),
    .w_br     (w_br),
    .pix_tl   (p_tl),
    .pix_tr   (p_tr),
    .pix_bl   (p_bl),
    .pix_br   (p_br),
    .push     (push),
    .push_pix (push_pix),
    .push_off (push_off)
  );

  // Hold finished results here while the sink stalls
  bws_out_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .reserve     (accept && (beat_cmd == CMD_SAMPLE)),
    .can_reserve (can_reserve),
    .push        (push),
    .push_pix    (push_pix),
    .push_off    (push_off),
    .pop_vld     (out_tvalid),
    .pop_rdy     (out_tready),
    .pop_pix     (pop_pix),
    .pop_off     (pop_off)
  );

  assign out_tdata    = pop_pix;
  assign out_tuser[0] = pop_off;

endmodule

`default_nettype wire
